### src/r30_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rule 30 sideways reconstruction block.
// No dependencies; imported by every module under src.
package r30_pkg;

	localparam int PRE_W   = 6;
	localparam int DESC_W  = 63;
	localparam int HOR_W   = 10;
	localparam int DEPTH_W = 10;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [HOR_W-1:0] HORIZON_RESET = 10'd64;

	// Register index as decoded from paddr[2].
	localparam logic REG_HORIZON = 1'b0;

	typedef struct packed {
		logic [PRE_W-1:0]  pre_len;
		logic [PRE_W-1:0]  cycle_len;
		logic [DESC_W-1:0] desc_bits;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [DEPTH_W-1:0] first_depth;
		logic               bad_description;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVOLVE,
		ST_RECON,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic              load;
		logic              evolve;
		logic              recon;
		logic [HOR_W-1:0]  step;
		logic [PRE_W-1:0]  idx;
	} ctl_t;

endpackage

### src/r30_row_unit.sv
`timescale 1ns / 1ps
// Shared row unit: one wide x ^ (y | z) update per cycle, for the rightward
// rule 30 evolution and for the sideways left-column rebuild. Uses r30_pkg.
module r30_row_unit import r30_pkg::*; #(
	parameter int W = 513
) (
	input  logic         recon,
	input  logic         inj,
	input  logic [W-1:0] row,
	input  logic [W-1:0] centre,
	input  logic [W-1:0] nb,
	output logic [W-1:0] result
);

	logic [W-1:0] x;
	logic [W-1:0] y;
	logic [W-1:0] z;

	always_comb begin
		if (recon) begin
			// left(t) = centre(t+1) ^ (centre(t) | right(t))
			x = {1'b0, centre[W-1:1]};
			y = centre;
			z = nb;
		end else begin
			// cell p: left neighbor ^ (self | right neighbor), cell 0 injected
			x = {row[W-2:0], inj};
			y = row;
			z = {1'b0, row[W-1:1]};
		end
		result = x ^ (y | z);
	end

endmodule

### src/r30_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: request intake and checks, step and index counters, result
// register with its handshake. Uses r30_pkg.
module r30_ctrl import r30_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req_data,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp_data,
	input  logic [HOR_W-1:0] h_eff,
	input  logic             hit,
	output ctl_t             ctl
);

	st_t              state_q;
	st_t              state_nxt;
	logic [HOR_W-1:0] t_q;
	logic [PRE_W-1:0] idx_q;
	logic [PRE_W-1:0] pre_q;
	logic [PRE_W-1:0] last_q;
	logic             found_q;
	logic [DEPTH_W-1:0] depth_q;
	logic             bad_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [PRE_W:0]   sum;
	logic             bad;
	logic             t_end;
	logic             rsp_free;

	assign sum      = {1'b0, req_data.pre_len} + {1'b0, req_data.cycle_len};
	assign bad      = (req_data.cycle_len == '0) || (sum > (PRE_W+1)'(DESC_W))
			|| ({{(HOR_W-PRE_W-1){1'b0}}, sum} > h_eff);
	assign t_end    = (t_q == h_eff);
	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid)
					state_nxt = bad ? ST_DONE : ST_EVOLVE;
			end
			ST_EVOLVE: begin
				if (t_end)
					state_nxt = ST_RECON;
			end
			ST_RECON: begin
				if (hit || t_end)
					state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = (state_q == ST_IDLE);
		ctl.load   = (state_q == ST_IDLE) && req_valid;
		ctl.evolve = (state_q == ST_EVOLVE);
		ctl.recon  = (state_q == ST_RECON);
		ctl.step   = t_q;
		ctl.idx    = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DONE && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					pre_q   <= req_data.pre_len;
					last_q  <= PRE_W'(sum - 1'b1);
					idx_q   <= '0;
					t_q     <= '0;
					bad_q   <= bad;
					found_q <= 1'b0;
					depth_q <= '0;
				end
			end
			ST_EVOLVE: begin
				t_q   <= t_end ? HOR_W'(1) : t_q + 1'b1;
				idx_q <= (idx_q == last_q) ? pre_q : idx_q + 1'b1;
			end
			ST_RECON: begin
				if (hit) begin
					found_q <= 1'b1;
					depth_q <= DEPTH_W'(t_q);
				end
				t_q <= t_q + 1'b1;
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_q.found           <= found_q;
					rsp_q.first_depth     <= depth_q;
					rsp_q.bad_description <= bad_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

### src/rule30_sideways_reconstruction.sv
`timescale 1ns / 1ps
// Rule 30 sideways reconstruction. A rejected request goes straight to the result
// register. Otherwise the block evolves the row over steps 0..h, then rebuilds the
// left column from depth 1 up to h (stopping at the first one bit), h being
// the saturated horizon. One request at a time; the single row unit sets that,
// so the next request is taken only after the result of the last one is registered.
// arst_n clears the sequencer and the result valid, and sets horizon to 64.
module rule30_sideways_reconstruction import r30_pkg::*; #(
	parameter int HORIZON_CAP = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// Rows hold cells 0..HORIZON_CAP (center trace and neighbor column) or
	// cells 1..HORIZON_CAP+1 (right-hand automaton row).
	localparam int W    = HORIZON_CAP + 1;
	localparam int IX_W = $clog2(W);
	localparam logic [HOR_W-1:0] HMAX = HOR_W'(HORIZON_CAP);

	logic [HOR_W-1:0]  horizon_q;
	logic [HOR_W-1:0]  h_eff;
	logic [DESC_W-1:0] desc_q;
	logic [W-1:0]      row_q;
	logic [W-1:0]      centre_q;
	logic [W-1:0]      nb_q;
	logic [W-1:0]      unit_out;
	logic [IX_W-1:0]   tix;
	logic              trace_bit;
	logic              cfg_wr;
	ctl_t              ctl;

	// Configuration: one register, written on the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_q <= HORIZON_RESET;
		end else if (cfg_wr && paddr[2] == REG_HORIZON) begin
			horizon_q <= pwdata[HOR_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_HORIZON) ? {{(DATA_W-HOR_W){1'b0}}, horizon_q} : '0;

	// Saturate the horizon to the row storage.
	assign h_eff = (horizon_q > HMAX) ? HMAX : horizon_q;

	r30_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.h_eff     (h_eff),
		.hit       (unit_out[0]),
		.ctl       (ctl)
	);

	// Trace bit for the current step: the sequencer walks the description index
	// through the preperiod once, then around the period.
	assign trace_bit = desc_q[ctl.idx];
	assign tix       = ctl.step[IX_W-1:0];

	r30_row_unit #(
		.W (W)
	) u_row (
		.recon  (ctl.recon),
		.inj    (trace_bit),
		.row    (row_q),
		.centre (centre_q),
		.nb     (nb_q),
		.result (unit_out)
	);

	// Row storage. Only entries 0..h of the trace and neighbor column are ever
	// read for a valid depth, and each evolve pass writes all of them, so they
	// need no clearing; the automaton row starts from all zeros per request.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			desc_q <= req_data.desc_bits;
			row_q  <= '0;
		end
		if (ctl.evolve) begin
			// Record trace and cell 1 at this step, then advance the row.
			centre_q[tix] <= trace_bit;
			nb_q[tix]     <= row_q[0];
			row_q         <= unit_out;
		end
		if (ctl.recon) begin
			// Shift one depth left: the old center becomes the right neighbor.
			nb_q     <= centre_q;
			centre_q <= unit_out;
		end
	end

	// A rejected description never reports a depth.
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.bad_description |-> !rsp_data.found
			&& rsp_data.first_depth == '0)
		else $error("rejected request carries a depth");

	// found and a nonzero depth go together.
	a_found_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.found == (rsp_data.first_depth != '0))
		else $error("found flag disagrees with depth");

	// A reported depth never exceeds the saturated horizon.
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.found |-> rsp_data.first_depth <= h_eff)
		else $error("depth beyond horizon");

	// After a request is taken, ready is low in the cycle after.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> !req_ready)
		else $error("ready right after acceptance");

endmodule
